@@ hw/rtl/efd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and constants of the escaped frame deframer.
// ----------------------------------------------------------------------------
package efd_pkg;

  localparam int EFD_BUF_DEPTH   = 64;
  localparam int EFD_QUEUE_DEPTH = 4;
  localparam int EFD_CFG_IDX_W   = 2;
  localparam int EFD_LEN_W       = 6;

  localparam logic [EFD_CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd0;
  localparam logic [EFD_CFG_IDX_W-1:0] CFG_STOP_BYTE   = 2'd1;
  localparam logic [EFD_CFG_IDX_W-1:0] CFG_ESCAPE_BYTE = 2'd2;

  localparam logic [7:0] START_BYTE_RST  = 8'd2;
  localparam logic [7:0] STOP_BYTE_RST   = 8'd3;
  localparam logic [7:0] ESCAPE_BYTE_RST = 8'd16;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_START,
    OP_CLOSE
  } efd_op_t;

  typedef struct packed {
    efd_op_t    op;
    logic [7:0] data;
  } efd_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CMD,
    BK_ONE,
    BK_DATA
  } efd_bk_state_t;

endpackage

@@ hw/rtl/efd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_if
// Valid/ready channels of the escaped frame deframer.
// ----------------------------------------------------------------------------
interface efd_in_if import efd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efd_out_if import efd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [7:0]           command;
  logic [7:0]           payload_byte;
  logic [EFD_LEN_W-1:0] payload_length;
  logic                 payload_empty;
  logic                 overflow;
  logic                 last;

  modport source (output valid, output command, output payload_byte, output payload_length,
                  output payload_empty, output overflow, output last, input ready);
  modport sink   (input valid, input command, input payload_byte, input payload_length,
                  input payload_empty, input overflow, input last, output ready);
endinterface

interface efd_cfg_if import efd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [EFD_CFG_IDX_W-1:0] index;
  logic [7:0]               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/efd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_front
// Byte classifier: holds the framing registers, tracks escape and frame
// state, and turns raw bytes into store, start or close operations.
// ----------------------------------------------------------------------------
module efd_front import efd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  efd_in_if.sink       in_bus,
  efd_cfg_if.sink      cfg_bus,
  output logic         q_valid,
  input  logic         q_ready,
  output efd_cmd_t     q_cmd
);

  logic [7:0] start_byte_r;
  logic [7:0] stop_byte_r;
  logic [7:0] escape_byte_r;
  logic       pend_r, pend_nxt;
  logic       in_frame_r, in_frame_nxt;
  logic       accept;
  logic       op_valid;
  efd_op_t    op;
  logic [7:0] b;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = q_ready;
  assign accept        = in_bus.valid && q_ready;
  assign b             = in_bus.rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= START_BYTE_RST;
      stop_byte_r   <= STOP_BYTE_RST;
      escape_byte_r <= ESCAPE_BYTE_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_START_BYTE:  start_byte_r  <= cfg_bus.data;
        CFG_STOP_BYTE:   stop_byte_r   <= cfg_bus.data;
        CFG_ESCAPE_BYTE: escape_byte_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  // escape first, then start, then stop
  always_comb begin
    op_valid     = 1'b0;
    op           = OP_PUT;
    pend_nxt     = pend_r;
    in_frame_nxt = in_frame_r;
    if (b == escape_byte_r) begin
      op_valid = pend_r;
      pend_nxt = !pend_r;
    end else if (b == start_byte_r) begin
      op_valid = 1'b1;
      if (pend_r) begin
        pend_nxt = 1'b0;
      end else begin
        op           = OP_START;
        in_frame_nxt = 1'b1;
      end
    end else if (b == stop_byte_r) begin
      if (pend_r) begin
        op_valid = 1'b1;
        pend_nxt = 1'b0;
      end else if (in_frame_r) begin
        op_valid     = 1'b1;
        op           = OP_CLOSE;
        in_frame_nxt = 1'b0;
      end
    end else if (in_frame_r) begin
      if (pend_r) begin
        pend_nxt = 1'b0;
      end else begin
        op_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      in_frame_r <= 1'b0;
    end else if (accept) begin
      pend_r     <= pend_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

  assign q_valid    = accept && op_valid;
  assign q_cmd.op   = op;
  assign q_cmd.data = b;

endmodule

@@ hw/rtl/efd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_queue
// Small operation queue between the classifier and the frame engine.
// ----------------------------------------------------------------------------
module efd_queue import efd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  efd_cmd_t push_cmd,
  output logic     pop_valid,
  input  logic     pop_ready,
  output efd_cmd_t pop_cmd
);

  localparam int PW = $clog2(EFD_QUEUE_DEPTH);
  localparam int CW = $clog2(EFD_QUEUE_DEPTH + 1);

  efd_cmd_t        slots_r [EFD_QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = count_r != CW'(EFD_QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(EFD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(EFD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/efd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_back
// Frame engine: stores decoded bytes, tracks fill and overflow, and plays a
// closed frame out as a command plus payload run through an output register.
// ----------------------------------------------------------------------------
module efd_back import efd_pkg::*; #(
  parameter int BUF_DEPTH = EFD_BUF_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  efd_cmd_t  q_cmd,
  efd_out_if.source out_bus
);

  localparam int IW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int WW = $clog2(BUF_DEPTH + 1);

  logic [7:0]           mem [BUF_DEPTH];
  logic [7:0]           rd_data_r;
  efd_bk_state_t        state_r, state_nxt;
  logic [WW-1:0]        wp_r, wp_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [7:0]           cmd_r;
  logic [IW-1:0]        plen;
  logic                 pop;
  logic                 mem_we;
  logic                 out_free;
  logic                 load_out;
  logic                 load_empty;
  logic                 last_byte;
  logic                 out_valid_r;
  logic [7:0]           command_r;
  logic [7:0]           payload_byte_r;
  logic [EFD_LEN_W-1:0] payload_length_r;
  logic                 payload_empty_r;
  logic                 overflow_r;
  logic                 last_r;

  assign plen      = IW'(wp_r - WW'(1));
  assign out_free  = !out_valid_r || out_bus.ready;
  assign last_byte = idx_r == plen;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && q_cmd.op == OP_CLOSE && wp_r != '0) begin
          state_nxt = BK_CMD;
        end
      end
      BK_CMD: begin
        state_nxt = (plen == '0) ? BK_ONE : BK_DATA;
      end
      BK_ONE: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_DATA: begin
        if (out_free && last_byte) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    mem_we     = 1'b0;
    wp_nxt     = wp_r;
    ovf_nxt    = ovf_r;
    idx_nxt    = idx_r;
    load_out   = 1'b0;
    load_empty = 1'b0;
    case (state_r)
      BK_IDLE: begin
        pop = q_valid;
        if (q_valid) begin
          case (q_cmd.op)
            OP_PUT: begin
              if (wp_r < WW'(BUF_DEPTH)) begin
                mem_we = 1'b1;
                wp_nxt = wp_r + WW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_START: begin
              wp_nxt  = '0;
              ovf_nxt = 1'b0;
            end
            OP_CLOSE: begin
              idx_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      BK_CMD: begin
        idx_nxt = IW'(1);
      end
      BK_ONE: begin
        load_out   = out_free;
        load_empty = 1'b1;
      end
      BK_DATA: begin
        load_out = out_free;
        if (out_free && !last_byte) begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      default: ;
    endcase
  end

  assign q_ready = pop;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r[IW-1:0]] <= q_cmd.data;
    end
    rd_data_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      wp_r        <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      ovf_r   <= ovf_nxt;
      idx_r   <= idx_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_CMD) begin
      cmd_r <= rd_data_r;
    end
    if (load_out) begin
      command_r        <= cmd_r;
      payload_byte_r   <= load_empty ? 8'd0 : rd_data_r;
      payload_length_r <= load_empty ? '0 : EFD_LEN_W'(plen);
      payload_empty_r  <= load_empty;
      overflow_r       <= ovf_r;
      last_r           <= load_empty || last_byte;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.command        = command_r;
  assign out_bus.payload_byte   = payload_byte_r;
  assign out_bus.payload_length = payload_length_r;
  assign out_bus.payload_empty  = payload_empty_r;
  assign out_bus.overflow       = overflow_r;
  assign out_bus.last           = last_r;

  // fill count never passes the buffer depth
  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= WW'(BUF_DEPTH))
    else $error("fill count beyond buffer depth");

  // operations are taken only between frames
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == BK_IDLE)
    else $error("queue popped during playout");

  // playout index stays inside the payload run
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DATA |-> (idx_r != '0 && idx_r <= plen))
    else $error("payload index out of range");

  // a non-empty frame close starts playout
  a_close_go: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_cmd.op == OP_CLOSE && wp_r != '0) |=> state_r == BK_CMD)
    else $error("closed frame not played out");

  // buffer contents hold while a frame is played out
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != BK_IDLE |-> !mem_we)
    else $error("buffer written during playout");

endmodule

@@ hw/rtl/escaped_frame_deframer_core.sv @@
`timescale 1ns / 1ps
// Path: a stop byte is registered in the 4-entry queue; once the engine takes the close and
//   passes BK_CMD, the first result is registered, then one a cycle while out ready holds.
// Throughput: one byte a cycle while the queue has room; a close holds the engine in BK_CMD,
//   then BK_ONE or BK_DATA to the last result, and input stalls only if the queue fills meanwhile.
// Reset: rst_n synchronous active low; control state clears, framing bytes return to 2/3/16,
//   frame buffer contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// escaped_frame_deframer_core
// Start/stop/escape byte-stuffing deframer: classifier, operation queue and
// frame engine.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_core import efd_pkg::*; #(
  parameter int BUF_DEPTH = EFD_BUF_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  efd_in_if.sink    in_bus,
  efd_cfg_if.sink   cfg_bus,
  efd_out_if.source out_bus
);

  logic     fq_valid;
  logic     fq_ready;
  efd_cmd_t fq_cmd;
  logic     qb_valid;
  logic     qb_ready;
  efd_cmd_t qb_cmd;

  efd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .cfg_bus (cfg_bus),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_cmd   (fq_cmd)
  );

  efd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  efd_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_cmd   (qb_cmd),
    .out_bus (out_bus)
  );

endmodule
